// ===== src/oesc_pkg.sv =====
// ----------------------------------------------------------------------------
// oesc_pkg
// Shared types, constants and arithmetic helpers for the orbit Euler stepper.
// ----------------------------------------------------------------------------
package oesc_pkg;

    localparam int WORD_W  = 48;
    localparam int FRAC_W  = 24;
    localparam int SQ_W    = 2 * WORD_W;
    localparam int PROD_W  = 3 * WORD_W;
    localparam int DIV_W   = 4 * WORD_W;
    localparam int REM_W   = WORD_W + 4;
    localparam int CNT_W   = 6;
    localparam int STEPS   = WORD_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GM       = 2'd2;

    localparam logic signed [WORD_W-1:0] CENTER_X_RST = 48'sd32212254720;
    localparam logic signed [WORD_W-1:0] CENTER_Y_RST = 48'sd18119393280;
    localparam logic [WORD_W-1:0]        GM_RST       = 48'd622117000000;

    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_DIFF, DP_SQ_X, DP_SQ_Y, DP_SQRT, DP_R2, DP_R3,
        DP_NUM_X, DP_DIV_X, DP_NUM_Y, DP_DIV_Y, DP_SING, DP_DISP, DP_POS, DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_CHECK, ST_R2, ST_R3,
        ST_NUM_X, ST_DIV_X, ST_NUM_Y, ST_DIV_Y, ST_SING, ST_DISP, ST_POS, ST_DONE
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   first;
    } dp_cmd_t;

    typedef struct packed {
        logic r_zero;
    } dp_status_t;

    // {overflow, clipped sum}
    function automatic logic [WORD_W:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        logic                   ovf;
        s   = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        ovf = s[WORD_W] != s[WORD_W-1];
        if (ovf) begin
            return {1'b1, (s[WORD_W] ? WMIN : WMAX)};
        end
        return {1'b0, s[WORD_W-1:0]};
    endfunction

    function automatic logic [WORD_W:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        logic                   ovf;
        s   = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        ovf = s[WORD_W] != s[WORD_W-1];
        if (ovf) begin
            return {1'b1, (s[WORD_W] ? WMIN : WMAX)};
        end
        return {1'b0, s[WORD_W-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // quotient to signed increment, top bit means the magnitude clips
    function automatic logic [WORD_W-1:0] incr(input logic [WORD_W-1:0] q, input logic neg);
        logic [WORD_W-1:0] m;
        m = q[WORD_W-1] ? WMAX : {1'b0, q[WORD_W-2:0]};
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage

// ===== src/orbit_euler_step_central_body_unit.sv =====
// ----------------------------------------------------------------------------
// orbit_euler_step_central_body_unit
// Semi-implicit Euler step of one body around a fixed central mass, Q24.24.
//
//   channel  direction  contents
//   s_*      in         tuser: opcode; tdata: load pos x/y, load disp x/y
//   m_*      out        tdata: pos x/y, disp x/y, singular, saturated
//   cfg_*    in         center_x, center_y, gm_step_sq writes
//
// A load beat is written into the body state in the accept cycle and leaves
// through the done state. A step beat runs the difference step, nine phases
// through the shared shift-add multiplier (ex^2, ey^2, r^2, r^3, two numerators),
// the square root and the two divisions, all one bit per cycle, and the check,
// displacement, position and done steps; a body on the center skips six phases.
// One beat is in work at a time; the next is taken while a result waits.
// Reset is synchronous and clears body state and loads the register defaults.
// ----------------------------------------------------------------------------
module orbit_euler_step_central_body_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // load_pos_x, load_pos_y, load_disp_x, load_disp_y
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata    // pos_x, pos_y, disp_x, disp_y, singular, saturated
);
    import oesc_pkg::*;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic [4*WORD_W+1:0]  out_data;

    oesc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    oesc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .load_data (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    assign m_tdata = {6'b0, out_data};

endmodule

// ===== src/oesc_ctrl.sv =====
// ----------------------------------------------------------------------------
// oesc_ctrl
// Sequencer: walks the datapath through load or step phases and hands off
// the finished beat to the output register.
// ----------------------------------------------------------------------------
module oesc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                opcode,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  oesc_pkg::dp_status_t status,
    output oesc_pkg::dp_cmd_t    cmd
);
    import oesc_pkg::*;

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             last;
    logic             out_free;

    assign last     = cnt_reg == CNT_W'(STEPS);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = opcode ? ST_DONE : ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_SQ_X;
            ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_R2, ST_R3,
            ST_NUM_X, ST_DIV_X, ST_NUM_Y, ST_DIV_Y: begin
                if (!last) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    unique case (state_reg)
                        ST_SQ_X:  state_next = ST_SQ_Y;
                        ST_SQ_Y:  state_next = ST_SQRT;
                        ST_SQRT:  state_next = ST_CHECK;
                        ST_R2:    state_next = ST_R3;
                        ST_R3:    state_next = ST_NUM_X;
                        ST_NUM_X: state_next = ST_DIV_X;
                        ST_DIV_X: state_next = ST_NUM_Y;
                        ST_NUM_Y: state_next = ST_DIV_Y;
                        default:  state_next = ST_DISP;
                    endcase
                end
            end
            ST_CHECK: state_next = status.r_zero ? ST_SING : ST_R2;
            ST_SING:  state_next = ST_POS;
            ST_DISP:  state_next = ST_POS;
            ST_POS:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.op        = DP_NOP;
        cmd.first     = cnt_reg == '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && opcode) begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_DIFF:  cmd.op = DP_DIFF;
            ST_SQ_X:  cmd.op = DP_SQ_X;
            ST_SQ_Y:  cmd.op = DP_SQ_Y;
            ST_SQRT:  cmd.op = DP_SQRT;
            ST_CHECK: cmd.op = DP_NOP;
            ST_R2:    cmd.op = DP_R2;
            ST_R3:    cmd.op = DP_R3;
            ST_NUM_X: cmd.op = DP_NUM_X;
            ST_DIV_X: cmd.op = DP_DIV_X;
            ST_NUM_Y: cmd.op = DP_NUM_Y;
            ST_DIV_Y: cmd.op = DP_DIV_Y;
            ST_SING:  cmd.op = DP_SING;
            ST_DISP:  cmd.op = DP_DISP;
            ST_POS:   cmd.op = DP_POS;
            ST_DONE: begin
                if (out_free) begin
                    cmd.op        = DP_OUT;
                    m_tvalid_next = 1'b1;
                end
            end
            default:  cmd.op = DP_NOP;
        endcase
    end

endmodule

// ===== src/oesc_dpath.sv =====
// ----------------------------------------------------------------------------
// oesc_dpath
// Datapath: body state, configuration registers, a shift-add multiplier,
// a digit-by-digit square root and a restoring divider, plus the output beat.
// ----------------------------------------------------------------------------
module oesc_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [oesc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oesc_pkg::WORD_W-1:0]         cfg_wdata,
    input  logic [4*oesc_pkg::WORD_W-1:0]       load_data,
    input  oesc_pkg::dp_cmd_t                   cmd,
    output oesc_pkg::dp_status_t                status,
    output logic [4*oesc_pkg::WORD_W+1:0]       out_data
);
    import oesc_pkg::*;

    logic signed [WORD_W-1:0] center_x_reg, center_y_reg;
    logic [WORD_W-1:0]        gm_reg;
    logic signed [WORD_W-1:0] pos_x_reg, pos_y_reg, disp_x_reg, disp_y_reg;
    logic signed [WORD_W-1:0] ex_reg, ey_reg, ix_reg;
    logic                     sat_reg, sing_reg;
    logic [PROD_W-1:0]        acc_reg, ma_reg, r3_reg, num_reg;
    logic [WORD_W-1:0]        mb_reg, root_reg, q_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         den_reg;
    logic [4*WORD_W+1:0]      out_reg;

    logic [WORD_W:0]          dx, dy, ax, ay, px, py;
    logic [REM_W-1:0]         rem_sh, trial;
    logic                     div_ge;
    logic [WORD_W-1:0]        iy;

    assign status.r_zero = root_reg == '0;
    assign out_data      = out_reg;

    assign dx     = sat_sub(center_x_reg, pos_x_reg);
    assign dy     = sat_sub(center_y_reg, pos_y_reg);
    assign iy     = incr(q_reg, ey_reg[WORD_W-1]);
    assign ax     = sat_add(disp_x_reg, ix_reg);
    assign ay     = sat_add(disp_y_reg, iy);
    assign px     = sat_add(pos_x_reg, disp_x_reg);
    assign py     = sat_add(pos_y_reg, disp_y_reg);
    assign rem_sh = {rem_reg[REM_W-3:0], sq_reg[SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign div_ge = den_reg <= {{(DIV_W-PROD_W){1'b0}}, num_reg};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            gm_reg       <= GM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_wdata;
                CFG_CENTER_Y: center_y_reg <= cfg_wdata;
                CFG_GM:       gm_reg       <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // body state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            disp_x_reg <= '0;
            disp_y_reg <= '0;
            sat_reg    <= 1'b0;
            sing_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                DP_LOAD: begin
                    pos_x_reg  <= load_data[0*WORD_W +: WORD_W];
                    pos_y_reg  <= load_data[1*WORD_W +: WORD_W];
                    disp_x_reg <= load_data[2*WORD_W +: WORD_W];
                    disp_y_reg <= load_data[3*WORD_W +: WORD_W];
                    sat_reg    <= 1'b0;
                    sing_reg   <= 1'b0;
                end
                DP_DIFF: begin
                    sat_reg  <= dx[WORD_W] | dy[WORD_W];
                    sing_reg <= 1'b0;
                end
                DP_NUM_Y: begin
                    if (cmd.first) begin
                        sat_reg <= sat_reg | q_reg[WORD_W-1];
                    end
                end
                DP_SING: sing_reg <= 1'b1;
                DP_DISP: begin
                    disp_x_reg <= ax[WORD_W-1:0];
                    disp_y_reg <= ay[WORD_W-1:0];
                    sat_reg    <= sat_reg | q_reg[WORD_W-1] | ax[WORD_W] | ay[WORD_W];
                end
                DP_POS: begin
                    pos_x_reg <= px[WORD_W-1:0];
                    pos_y_reg <= py[WORD_W-1:0];
                    sat_reg   <= sat_reg | px[WORD_W] | py[WORD_W];
                end
                default: ;
            endcase
        end
    end

    // arithmetic units, payload only
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_DIFF: begin
                ex_reg <= dx[WORD_W-1:0];
                ey_reg <= dy[WORD_W-1:0];
            end
            DP_SQ_X, DP_SQ_Y, DP_R2, DP_R3, DP_NUM_X, DP_NUM_Y: begin
                if (cmd.first) begin
                    unique case (cmd.op)
                        DP_SQ_X: begin
                            ma_reg  <= PROD_W'(mag(ex_reg));
                            mb_reg  <= mag(ex_reg);
                            acc_reg <= '0;
                        end
                        DP_SQ_Y: begin
                            // keeps accumulating onto ex squared
                            ma_reg <= PROD_W'(mag(ey_reg));
                            mb_reg <= mag(ey_reg);
                        end
                        DP_R2: begin
                            ma_reg  <= PROD_W'(root_reg);
                            mb_reg  <= root_reg;
                            acc_reg <= '0;
                        end
                        DP_R3: begin
                            ma_reg  <= PROD_W'(acc_reg[SQ_W-1:0]);
                            mb_reg  <= root_reg;
                            acc_reg <= '0;
                        end
                        DP_NUM_X: begin
                            r3_reg  <= acc_reg;
                            ma_reg  <= PROD_W'(gm_reg);
                            mb_reg  <= mag(ex_reg);
                            acc_reg <= '0;
                        end
                        default: begin
                            ix_reg  <= incr(q_reg, ex_reg[WORD_W-1]);
                            ma_reg  <= PROD_W'(gm_reg);
                            mb_reg  <= mag(ey_reg);
                            acc_reg <= '0;
                        end
                    endcase
                end else begin
                    if (mb_reg[0]) begin
                        acc_reg <= acc_reg + ma_reg;
                    end
                    ma_reg <= {ma_reg[PROD_W-2:0], 1'b0};
                    mb_reg <= {1'b0, mb_reg[WORD_W-1:1]};
                end
            end
            DP_SQRT: begin
                if (cmd.first) begin
                    sq_reg   <= acc_reg[SQ_W-1:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                end else begin
                    sq_reg <= {sq_reg[SQ_W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[WORD_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[WORD_W-2:0], 1'b0};
                    end
                end
            end
            DP_DIV_X, DP_DIV_Y: begin
                if (cmd.first) begin
                    // numerator gm*|e| scaled by two fraction widths
                    num_reg <= {acc_reg[PROD_W-2*FRAC_W-1:0], {(2*FRAC_W){1'b0}}};
                    den_reg <= {1'b0, r3_reg, {(DIV_W-PROD_W-1){1'b0}}};
                    q_reg   <= '0;
                end else begin
                    if (div_ge) begin
                        num_reg <= num_reg - den_reg[PROD_W-1:0];
                    end
                    q_reg   <= {q_reg[WORD_W-2:0], div_ge};
                    den_reg <= {1'b0, den_reg[DIV_W-1:1]};
                end
            end
            default: ;
        endcase
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_OUT) begin
            out_reg <= {sat_reg, sing_reg, disp_y_reg, disp_x_reg, pos_y_reg, pos_x_reg};
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the orbit Euler stepper. Load and step beats go in
// on the stream input. A bit-exact predictor computes each expected state and
// flag, and the results are checked field by field. The run has four phases.
// Each phase uses its own gm setting and idle/stall mix; the first and last use the reset center.
// ----------------------------------------------------------------------------
module tb;
    import oesc_pkg::*;

    typedef struct {
        logic         op;
        logic [191:0] data;
    } body_cmd_t;

    typedef struct {
        logic signed [47:0] px, py, dx, dy;
        logic               sing, sat;
    } body_state_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [47:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;

    orbit_euler_step_central_body_unit dut (.*);

    always #5 aclk = ~aclk;

    body_cmd_t   pending_cmds[$];
    body_state_t expected_states[$];
    logic signed [47:0] ctr_x, ctr_y;
    logic [47:0]        gm;
    logic signed [47:0] st_px, st_py, st_dx, st_dy;
    int  send_idle = 0, recv_stall = 0;
    int  errors = 0, n_load = 0, n_step = 0, n_sing = 0, n_sat = 0, n_checked = 0;
    logic beat_taken = 1'b0;

    function automatic logic signed [47:0] clip(input logic signed [48:0] s, inout bit fl);
        if (s[48] != s[47]) begin
            fl = 1'b1;
            return s[48] ? WMIN : WMAX;
        end
        return s[47:0];
    endfunction

    function automatic logic signed [47:0] pull(input logic signed [47:0] e,
                                                input logic [255:0] r3, inout bit fl);
        logic [255:0] m, q;
        logic [47:0]  lim;
        m = e[47] ? ({208'b0, ~e} + 256'd1) : {208'b0, e};
        q = (({208'b0, gm} * m) << (2 * FRAC_W)) / r3;
        if (q > {208'b0, WMAX}) begin
            fl = 1'b1;
            lim = WMAX;
        end else begin
            lim = q[47:0];
        end
        return e[47] ? -lim : lim;
    endfunction

    // advance the body model by one beat and return the state it reports
    function automatic body_state_t advance_body(input logic op, input logic [191:0] d);
        body_state_t res;
        bit sat, sing;
        logic signed [47:0] ex, ey, ix, iy;
        logic [255:0] mx, my, sq, r3, c2;
        logic [63:0] r, c;
        sat = 0;
        sing = 0;
        if (op) begin
            {st_dy, st_dx, st_py, st_px} = d;
            n_load++;
        end else begin
            n_step++;
            ex = clip({ctr_x[47], ctr_x} - {st_px[47], st_px}, sat);
            ey = clip({ctr_y[47], ctr_y} - {st_py[47], st_py}, sat);
            mx = ex[47] ? ({208'b0, ~ex} + 256'd1) : {208'b0, ex};
            my = ey[47] ? ({208'b0, ~ey} + 256'd1) : {208'b0, ey};
            sq = mx * mx + my * my;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                c2 = {192'b0, c} * {192'b0, c};
                if (c2 <= sq) r = c;
            end
            if (r == 0) begin
                sing = 1;
            end else begin
                r3 = {192'b0, r} * {192'b0, r} * {192'b0, r};
                ix = pull(ex, r3, sat);
                iy = pull(ey, r3, sat);
                st_dx = clip({st_dx[47], st_dx} + {ix[47], ix}, sat);
                st_dy = clip({st_dy[47], st_dy} + {iy[47], iy}, sat);
            end
            st_px = clip({st_px[47], st_px} + {st_dx[47], st_dx}, sat);
            st_py = clip({st_py[47], st_py} + {st_dy[47], st_dy}, sat);
        end
        if (sing) n_sing++;
        if (sat) n_sat++;
        res.px = st_px; res.py = st_py; res.dx = st_dx; res.dy = st_dy;
        res.sing = sing; res.sat = sat;
        return res;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    task automatic push_cmd(input logic op, input logic [47:0] px, py, dx, dy);
        body_cmd_t c;
        c.op = op;
        c.data = {dy, dx, py, px};
        pending_cmds.push_back(c);
    endtask

    // position a body up to 512 pixels off center per axis with a modest speed, then queue its steps
    task automatic push_orbit(input int steps);
        logic signed [47:0] ox, oy, vx, vy;
        ox = $signed({14'b0, 10'($urandom_range(0, 1023)), 24'b0}) - (48'sd512 <<< 24)
             + $signed({24'b0, 24'($urandom_range(0, 32'hffffff))});
        oy = $signed({14'b0, 10'($urandom_range(0, 1023)), 24'b0}) - (48'sd512 <<< 24)
             + $signed({24'b0, 24'($urandom_range(0, 32'hffffff))});
        vx = $signed({20'b0, 28'($urandom_range(0, 32'h0fff_ffff))}) - (48'sd8 <<< 24);
        vy = $signed({20'b0, 28'($urandom_range(0, 32'h0fff_ffff))}) - (48'sd8 <<< 24);
        push_cmd(1'b1, ctr_x + ox, ctr_y + oy, vx, vy);
        repeat (steps) push_cmd(1'b0, rand48(), rand48(), rand48(), rand48());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CENTER_X: ctr_x = val;
            CFG_CENTER_Y: ctr_y = val;
            default:      gm = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_states.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    // random part of one phase: mostly orbit runs, some full-range noise
    task automatic run_phase(input int items, input int idle, input int stall);
        int n;
        int steps;
        send_idle = idle;
        recv_stall = stall;
        n = 0;
        while (n < items) begin
            if ($urandom_range(0, 9) < 7) begin
                steps = int'($urandom_range(3, 12));
                push_orbit(steps);
                n = n + 1 + steps;
            end else begin
                push_cmd(1'($urandom_range(0, 1)), rand48(), rand48(), rand48(), rand48());
                n++;
            end
        end
        drain();
    endtask

    // prediction and result check both at the rising edge
    always @(posedge aclk) begin
        body_state_t e;
        beat_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_states.push_back(advance_body(s_tuser, s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end else begin
                e = expected_states.pop_front();
                n_checked++;
                if (m_tdata[47:0] !== e.px || m_tdata[95:48] !== e.py ||
                    m_tdata[143:96] !== e.dx || m_tdata[191:144] !== e.dy ||
                    m_tdata[192] !== e.sing || m_tdata[193] !== e.sat ||
                    m_tdata[199:194] !== '0) begin
                    $display("%0t: mismatch exp pos %h %h disp %h %h sing %b sat %b",
                             $time, e.px, e.py, e.dx, e.dy, e.sing, e.sat);
                    $display("%0t:          got pos %h %h disp %h %h sing %b sat %b",
                             $time, m_tdata[47:0], m_tdata[95:48], m_tdata[143:96],
                             m_tdata[191:144], m_tdata[192], m_tdata[193]);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        body_cmd_t c;
        if (aresetn) begin
            if (!s_tvalid || beat_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= c.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall;
        end
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        ctr_x = CENTER_X_RST;
        ctr_y = CENTER_Y_RST;
        gm = GM_RST;
        st_px = '0; st_py = '0; st_dx = '0; st_dy = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: step from reset, body on center, range extremes
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, CENTER_X_RST, CENTER_Y_RST, '0, '0);
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, CENTER_X_RST, CENTER_Y_RST, 48'sd1 <<< 24, -(48'sd1 <<< 24));
        push_cmd(1'b0, '1, '1, '1, '1);
        push_cmd(1'b1, WMAX, WMIN, WMAX, WMIN);
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, WMIN, WMAX, WMIN, WMAX);
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, CENTER_X_RST + 1, CENTER_Y_RST, '0, '0);
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, CENTER_X_RST, CENTER_Y_RST - 1, WMAX, '0);
        push_cmd(1'b0, '0, '0, '0, '0);
        push_cmd(1'b1, '0, '0, '0, '0);
        push_cmd(1'b0, WMAX, WMAX, WMAX, WMAX);
        drain();

        run_phase(360, 0, 0);

        write_reg(CFG_CENTER_X, rand48() & 48'h00ff_ffff_ffff);
        write_reg(CFG_CENTER_Y, rand48() & 48'h00ff_ffff_ffff);
        write_reg(CFG_GM, {8'b0, 8'($urandom_range(0, 255)), $urandom});
        run_phase(360, 63, 0);

        write_reg(CFG_CENTER_X, WMAX);
        write_reg(CFG_CENTER_Y, WMIN);
        write_reg(CFG_GM, '1);
        run_phase(360, 0, 63);

        write_reg(CFG_CENTER_X, WMIN);
        write_reg(CFG_CENTER_Y, WMAX);
        write_reg(CFG_GM, '0);
        push_cmd(1'b1, WMIN, WMAX, 48'sd5, -48'sd5);
        push_cmd(1'b0, '0, '0, '0, '0);
        drain();
        write_reg(CFG_CENTER_X, CENTER_X_RST);
        write_reg(CFG_CENTER_Y, CENTER_Y_RST);
        write_reg(CFG_GM, GM_RST + 48'($urandom_range(0, 1 << 20)));
        run_phase(360, 6, 6);

        repeat (20) @(posedge aclk);
        $display("covered %0d loads and %0d steps, %0d results checked", n_load, n_step,
                 n_checked);
        $display("%0d singular and %0d saturated results, %0d errors", n_sing, n_sat, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/oesc_pkg.sv
src/oesc_ctrl.sv
src/oesc_dpath.sv
src/orbit_euler_step_central_body_unit.sv
bench/tb.sv
